// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of the project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, off while reset is held
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that a condition never holds, off while reset is held
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/sfcc_pkg.sv -----
// Shared types and constants of the sensor frame CRC checker and converter
package sfcc_pkg;

    // Configuration register indexes and reset values
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] REG_CRC_POLY = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_CRC_INIT = 1'b1;
    localparam logic [7:0] CRC_POLY_RESET = 8'h31;
    localparam logic [7:0] CRC_INIT_RESET = 8'hFF;

    // Depth of the frame queue between front and back
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // One checked frame, handed from the front to the back
    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic        temp_ok;
        logic        hum_ok;
    } sfcc_rec_t;

endpackage

// ----- rtl/sfcc_front.sv -----
// Front end: byte framing, CRC-8 per word and configuration registers
module sfcc_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfcc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sfcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [7:0]                       data_byte,
    input  logic                             frame_start,
    input  logic                             q_full,
    output logic                             q_push,
    output sfcc_pkg::sfcc_rec_t              q_rec
);
    import sfcc_pkg::*;

    // Byte positions within a frame
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // One byte of CRC-8, MSB first, implicit top bit of the generator
    function automatic logic [7:0] crc8_byte(input logic [7:0] rem,
                                             input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] r;
        r = rem ^ b;
        for (int k = 0; k < 8; k++) begin
            if (r[7])
                r = {r[6:0], 1'b0} ^ poly;
            else
                r = {r[6:0], 1'b0};
        end
        return r;
    endfunction

    logic [7:0]  poly_reg;
    logic [7:0]  init_reg;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] temp_word_reg, temp_word_next;
    logic        temp_good_reg, temp_good_next;
    logic [7:0]  hum_hi_reg, hum_hi_next;
    logic [7:0]  hum_lo_reg, hum_lo_next;

    logic        accept;
    logic [2:0]  pos;
    logic [7:0]  crc_in;
    logic [7:0]  crc_new;
    logic        hum_match;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Resynchronize on frame start, treat unused positions as the first byte
    assign pos       = (frame_start || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;
    assign crc_in    = (pos == POS_T_HI || pos == POS_H_HI) ? init_reg : crc_reg;
    assign crc_new   = crc8_byte(crc_in, data_byte, poly_reg);
    assign hum_match = (crc_reg == data_byte);

    // Advance frame state on each byte transfer
    always_comb
    begin
        pos_next       = pos + 3'd1;
        crc_next       = crc_reg;
        temp_word_next = temp_word_reg;
        temp_good_next = temp_good_reg;
        hum_hi_next    = hum_hi_reg;
        hum_lo_next    = hum_lo_reg;
        case (pos)
            POS_T_HI:
            begin
                crc_next       = crc_new;
                temp_word_next = {data_byte, 8'd0};
            end
            POS_T_LO:
            begin
                crc_next       = crc_new;
                temp_word_next = {temp_word_reg[15:8], data_byte};
            end
            POS_T_CRC:
            begin
                temp_good_next = (crc_reg == data_byte);
                crc_next       = init_reg;
            end
            POS_H_HI:
            begin
                crc_next    = crc_new;
                hum_hi_next = data_byte;
            end
            POS_H_LO:
            begin
                crc_next    = crc_new;
                hum_lo_next = data_byte;
            end
            default:
            begin
                crc_next = init_reg;
                pos_next = POS_T_HI;
            end
        endcase
    end

    // Hand a finished frame to the queue on the last byte
    assign q_push         = accept && (pos == POS_H_CRC);
    assign q_rec.temp_raw = temp_word_reg;
    assign q_rec.hum_raw  = {hum_hi_reg, hum_lo_reg};
    assign q_rec.temp_ok  = temp_good_reg;
    assign q_rec.hum_ok   = hum_match;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= CRC_POLY_RESET;
            init_reg <= CRC_INIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_CRC_POLY)
                poly_reg <= cfg_wdata;
            else if (cfg_addr == REG_CRC_INIT)
                init_reg <= cfg_wdata;
        end
    end

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT_RESET;
            temp_word_reg <= 16'd0;
            temp_good_reg <= 1'b0;
            hum_hi_reg    <= 8'd0;
            hum_lo_reg    <= 8'd0;
        end
        else if (accept)
        begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            temp_word_reg <= temp_word_next;
            temp_good_reg <= temp_good_next;
            hum_hi_reg    <= hum_hi_next;
            hum_lo_reg    <= hum_lo_next;
        end
    end

endmodule

// ----- rtl/sfcc_queue.sv -----
// Small frame queue between the front and back ends
module sfcc_queue
#(
    parameter int DEPTH = sfcc_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  sfcc_pkg::sfcc_rec_t  push_rec,
    output logic                 full,
    input  logic                 pop,
    output sfcc_pkg::sfcc_rec_t  pop_rec,
    output logic                 empty
);
    import sfcc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    sfcc_rec_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_rec = slot_reg[rd_ptr_reg];

    // Advance pointers with explicit wrap
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

// ----- rtl/sfcc_back.sv -----
// Back end: scaling of raw words to centi-units and the output register
module sfcc_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  sfcc_pkg::sfcc_rec_t  q_rec,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [14:0]   temperature_centi,
    output logic [13:0]          humidity_centi,
    output logic                 temperature_crc_ok,
    output logic                 humidity_crc_ok,
    output logic                 frame_ok
);
    import sfcc_pkg::*;

    localparam logic [14:0] TEMP_SPAN  = 15'd17500;
    localparam logic [13:0] HUM_SPAN   = 14'd10000;
    localparam logic [31:0] ROUND_HALF = 32'd32767;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

    logic        s1_valid_reg;
    logic [30:0] s1_temp_prod_reg;
    logic [29:0] s1_hum_prod_reg;
    logic        s1_temp_ok_reg;
    logic        s1_hum_ok_reg;

    logic        out_valid_reg;
    logic [14:0] temp_out_reg;
    logic [13:0] hum_out_reg;
    logic        temp_ok_out_reg;
    logic        hum_ok_out_reg;
    logic        frame_ok_out_reg;

    logic        advance;
    logic [31:0] temp_x, temp_acc;
    logic [31:0] hum_x, hum_acc;
    logic [15:0] temp_q, hum_q;
    logic signed [15:0] temp_c;
    logic        ok;

    assign advance = !out_valid_reg || out_ready;
    assign q_pop   = advance && !q_empty;

    // Divide by 65535 with rounding: x / 65535 == (x + (x >> 16) + 1) >> 16
    assign temp_x   = {1'b0, s1_temp_prod_reg} + ROUND_HALF;
    assign temp_acc = temp_x + {16'd0, temp_x[31:16]} + 32'd1;
    assign temp_q   = temp_acc[31:16];
    assign hum_x    = {2'b00, s1_hum_prod_reg} + ROUND_HALF;
    assign hum_acc  = hum_x + {16'd0, hum_x[31:16]} + 32'd1;
    assign hum_q    = hum_acc[31:16];
    assign temp_c   = $signed({1'b0, temp_q[14:0]}) - TEMP_OFFSET;
    assign ok       = s1_temp_ok_reg && s1_hum_ok_reg;

    // Multiply stage and output stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_empty;
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Scale raw words, then round and offset into the output register
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_temp_prod_reg <= 31'(TEMP_SPAN) * 31'(q_rec.temp_raw);
            s1_hum_prod_reg  <= 30'(HUM_SPAN) * 30'(q_rec.hum_raw);
            s1_temp_ok_reg   <= q_rec.temp_ok;
            s1_hum_ok_reg    <= q_rec.hum_ok;
            temp_out_reg     <= ok ? temp_c[14:0] : 15'd0;
            hum_out_reg      <= ok ? hum_q[13:0] : 14'd0;
            temp_ok_out_reg  <= s1_temp_ok_reg;
            hum_ok_out_reg   <= s1_hum_ok_reg;
            frame_ok_out_reg <= ok;
        end
    end

    assign out_valid          = out_valid_reg;
    assign temperature_centi  = $signed(temp_out_reg);
    assign humidity_centi     = hum_out_reg;
    assign temperature_crc_ok = temp_ok_out_reg;
    assign humidity_crc_ok    = hum_ok_out_reg;
    assign frame_ok           = frame_ok_out_reg;

endmodule

// ----- rtl/sensor_frame_crc_convert_top.sv -----
// Top level of the sensor frame CRC checker and converter
//
// Input stream s_*: one frame byte per transfer, s_tdata[7:0] the byte,
// s_tuser[0] marks the first byte of a frame and resynchronizes mid-frame.
// A frame is temperature high, low, CRC, then humidity high, low, CRC.
// Output stream m_*: one result per complete frame, values in hundredths
// (temperature signed), both zero unless both word CRCs matched.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_addr
// (0: CRC polynomial, reset 0x31; 1: CRC initial value, reset 0xFF).
// Throughput: one byte per cycle while the queue is not full, set by the
// combinational byte CRC in the front end. After the last frame byte is
// taken, its result passes the queue, the multiply stage and the output register.
// Finished frames wait in a queue of QUEUE_DEPTH entries; when the
// receiver stalls, the output register holds and the queue fills, and
// s_tready drops only once the queue is full.
// Reset clears the frame position, the queue and the output valid bit,
// and restores the configuration registers to their reset values.
module sensor_frame_crc_convert_top
#(
    parameter int QUEUE_DEPTH = sfcc_pkg::QUEUE_DEPTH_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [sfcc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [sfcc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [7:0] data_byte
    input  logic [0:0]                       s_tuser,   // [0] frame_start
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [14:0] temperature_centi,
                                                        // [28:15] humidity_centi
    output logic [2:0]                       m_tuser    // [0] temperature_crc_ok,
                                                        // [1] humidity_crc_ok, [2] frame_ok
);
    import sfcc_pkg::*;

    sfcc_rec_t          push_rec;
    sfcc_rec_t          pop_rec;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               temperature_crc_ok;
    logic               humidity_crc_ok;
    logic               frame_ok;

    sfcc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .data_byte   (s_tdata),
        .frame_start (s_tuser[0]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_rec       (push_rec)
    );

    sfcc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_rec (push_rec),
        .full     (q_full),
        .pop      (q_pop),
        .pop_rec  (pop_rec),
        .empty    (q_empty)
    );

    sfcc_back u_back
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_empty            (q_empty),
        .q_rec              (pop_rec),
        .q_pop              (q_pop),
        .out_valid          (m_tvalid),
        .out_ready          (m_tready),
        .temperature_centi  (temperature_centi),
        .humidity_centi     (humidity_centi),
        .temperature_crc_ok (temperature_crc_ok),
        .humidity_crc_ok    (humidity_crc_ok),
        .frame_ok           (frame_ok)
    );

    // Pack result fields
    assign m_tdata = {3'd0, humidity_centi, temperature_centi};
    assign m_tuser = {frame_ok, humidity_crc_ok, temperature_crc_ok};

endmodule

// ----- rtl/sfcc_checker.sv -----
// Port-level checks of the sensor frame CRC converter, bound to the top level
`include "assert_macros.svh"

module sfcc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Stalled result holds
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Frame status is the AND of both word checks
    `ASSERT_CLK(a_frame_ok, m_tvalid |-> (m_tuser[2] == (m_tuser[0] && m_tuser[1])), "frame_ok disagrees with word checks")

    // Failed frames carry zero values
    `ASSERT_CLK(a_fail_zero, m_tvalid && !m_tuser[2] |-> (m_tdata == 32'd0), "nonzero values on failed frame")

    // Good frames stay in range
    `ASSERT_CLK(a_range, m_tvalid && m_tuser[2] |-> (m_tdata[28:15] <= 14'd10000) && ($signed(m_tdata[14:0]) >= -15'sd4500) && ($signed(m_tdata[14:0]) <= 15'sd13000), "converted value out of range")

endmodule

bind sensor_frame_crc_convert_top sfcc_checker u_sfcc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the sensor frame CRC checker and converter top level
`timescale 1ns / 100ps

module tb_top;

    import sfcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_OFF_LEN   = 400;

    // Byte positions within a frame
    localparam logic [2:0] POS_TEMP_HI  = 3'd0;
    localparam logic [2:0] POS_TEMP_LO  = 3'd1;
    localparam logic [2:0] POS_TEMP_CRC = 3'd2;
    localparam logic [2:0] POS_HUM_HI   = 3'd3;
    localparam logic [2:0] POS_HUM_LO   = 3'd4;
    localparam logic [2:0] POS_HUM_CRC  = 3'd5;

    typedef struct {
        logic [7:0] data;
        logic       start;
    } frame_byte_t;

    typedef struct {
        logic signed [14:0] temp;
        logic [13:0]        hum;
        logic               temp_ok;
        logic               hum_ok;
        logic               frame_ok;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;

    sensor_frame_crc_convert_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Bytes waiting to be sent and readings waiting to come out
    frame_byte_t byte_queue[$];
    reading_t    reading_queue[$];

    // Shadow of the block: configuration and frame state
    logic [7:0]  cfg_poly;
    logic [7:0]  cfg_init;
    logic [2:0]  frame_pos;
    logic [7:0]  crc_run;
    logic [15:0] temp_word;
    logic        temp_good;
    logic [7:0]  hum_hi;
    logic [7:0]  hum_lo;

    int  error_count = 0;
    int  idle_cycles = 0;
    logic in_fire = 1'b0;
    int  in_gap_pct = 0;
    int  out_stall_pct = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_req = 0;
    int  hold_left = 0;
    bit  need_start = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("tb_top: mismatch: %s", msg);
    endtask

    // One byte through the CRC-8 register, MSB first
    function automatic logic [7:0] crc8_step(input logic [7:0] rem, input logic [7:0] b,
                                             input logic [7:0] poly);
        logic [7:0] r;
        r = rem ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (r[7])
                r = (r << 1) ^ poly;
            else
                r = r << 1;
        end
        return r;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_step(crc8_step(cfg_init, w[15:8], cfg_poly), w[7:0], cfg_poly);
    endfunction

    // Advance the shadow frame state by one accepted byte, queue a reading on the last byte
    task automatic predict_byte(input logic [7:0] b, input logic start);
        reading_t    r;
        logic [2:0]  p;
        logic        hum_match;
        int unsigned traw;
        int unsigned hraw;
        int unsigned tv;
        int unsigned hv;
        int          t_centi;
        p = frame_pos;
        if (start || p > POS_HUM_CRC)
            p = POS_TEMP_HI;
        frame_pos = p + 3'd1;
        case (p)
            POS_TEMP_HI:
            begin
                crc_run = crc8_step(cfg_init, b, cfg_poly);
                temp_word = {b, 8'h00};
            end
            POS_TEMP_LO:
            begin
                crc_run = crc8_step(crc_run, b, cfg_poly);
                temp_word[7:0] = b;
            end
            POS_TEMP_CRC:
            begin
                temp_good = (crc_run == b);
                crc_run = cfg_init;
            end
            POS_HUM_HI:
            begin
                crc_run = crc8_step(cfg_init, b, cfg_poly);
                hum_hi = b;
            end
            POS_HUM_LO:
            begin
                crc_run = crc8_step(crc_run, b, cfg_poly);
                hum_lo = b;
            end
            default:
            begin
                hum_match = (crc_run == b);
                r.temp_ok = temp_good;
                r.hum_ok = hum_match;
                r.frame_ok = temp_good & hum_match;
                r.temp = '0;
                r.hum = '0;
                if (r.frame_ok)
                begin
                    traw = 32'(temp_word);
                    hraw = 32'({hum_hi, hum_lo});
                    tv = (17500 * traw + 32767) / 65535;
                    hv = (10000 * hraw + 32767) / 65535;
                    t_centi = int'(tv) - 4500;
                    r.temp = t_centi[14:0];
                    r.hum = hv[13:0];
                end
                reading_queue.push_back(r);
                crc_run = cfg_init;
                frame_pos = POS_TEMP_HI;
            end
        endcase
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic start);
        frame_byte_t fb;
        fb.data = b;
        fb.start = start;
        byte_queue.push_back(fb);
    endtask

    // Queue a full frame, optionally with a corrupted CRC on either word
    task automatic queue_frame(input logic [15:0] t, input logic [15:0] h,
                               input bit t_bad, input bit h_bad, input logic start);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = word_crc(t);
        hc = word_crc(h);
        if (t_bad)
            tc = tc ^ 8'($urandom_range(1, 255));
        if (h_bad)
            hc = hc ^ 8'($urandom_range(1, 255));
        push_byte(t[15:8], start);
        push_byte(t[7:0], 1'b0);
        push_byte(tc, 1'b0);
        push_byte(h[15:8], 1'b0);
        push_byte(h[7:0], 1'b0);
        push_byte(hc, 1'b0);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 19))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames, with broken frames and stray bytes mixed in
    task automatic queue_random(input int n_items);
        int count;
        int r;
        int len;
        count = 0;
        while (count < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 85)
            begin
                queue_frame(rand_word(), rand_word(), $urandom_range(0, 99) < 15,
                            $urandom_range(0, 99) < 15,
                            need_start | 1'($urandom_range(0, 1)));
                need_start = 1'b0;
                count += 6;
            end
            else if (r < 94)
            begin
                len = $urandom_range(1, 5);
                push_byte(8'($urandom), need_start | 1'($urandom_range(0, 1)));
                for (int i = 1; i < len; i++)
                    push_byte(8'($urandom), 1'b0);
                need_start = 1'b1;
                count += len;
            end
            else
            begin
                push_byte(8'($urandom), 1'($urandom_range(0, 1)));
                need_start = 1'b1;
                count += 1;
            end
        end
    endtask

    // Write both registers back to back while the block is idle
    task automatic write_regs(input logic [7:0] poly, input logic [7:0] init);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= REG_CRC_POLY;
        cfg_wdata <= poly;
        @(negedge clk);
        cfg_addr <= REG_CRC_INIT;
        cfg_wdata <= init;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_poly = poly;
        cfg_init = init;
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || s_tvalid || reading_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] poly, input logic [7:0] init, input int n_items,
                             input int gap_pct, input int stall_pct, input bit hold_off);
        write_regs(poly, init);
        in_gap_pct = gap_pct;
        out_stall_pct = stall_pct;
        if (hold_off)
        begin
            @(posedge clk);
            hold_req = HOLD_OFF_LEN;
        end
        queue_random(n_items);
        wait_idle();
    endtask

    // Sender: offer queued bytes, hold until taken, insert random gaps
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (s_tvalid && !in_fire)
        begin
            s_tvalid <= 1'b1;
        end
        else if (gap_left != 0)
        begin
            gap_left--;
            s_tvalid <= 1'b0;
        end
        else if (byte_queue.size() != 0)
        begin
            frame_byte_t fb;
            fb = byte_queue.pop_front();
            s_tdata <= fb.data;
            s_tuser <= fb.start;
            s_tvalid <= 1'b1;
            if ($urandom_range(0, 99) < in_gap_pct)
                gap_left = pick_gap();
        end
        else
        begin
            s_tvalid <= 1'b0;
        end
    end

    // Receiver: long hold-off on request, otherwise random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req = 0;
            m_tready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 99) < out_stall_pct)
                stall_left = pick_gap();
        end
    end

    // Monitor: predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire <= 1'b0;
        end
        else
        begin
            in_fire <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (reading_queue.size() == 0)
                begin
                    report_mismatch($sformatf("result with no frame pending, tdata %h tuser %b",
                                              m_tdata, m_tuser));
                end
                else
                begin
                    reading_t exp_r;
                    exp_r = reading_queue.pop_front();
                    if (m_tdata[14:0] !== exp_r.temp)
                        report_mismatch($sformatf("temperature_centi expected %0d got %0d",
                                                  exp_r.temp, $signed(m_tdata[14:0])));
                    if (m_tdata[28:15] !== exp_r.hum)
                        report_mismatch($sformatf("humidity_centi expected %0d got %0d",
                                                  exp_r.hum, m_tdata[28:15]));
                    if (m_tuser[0] !== exp_r.temp_ok)
                        report_mismatch($sformatf("temperature_crc_ok expected %b got %b",
                                                  exp_r.temp_ok, m_tuser[0]));
                    if (m_tuser[1] !== exp_r.hum_ok)
                        report_mismatch($sformatf("humidity_crc_ok expected %b got %b",
                                                  exp_r.hum_ok, m_tuser[1]));
                    if (m_tuser[2] !== exp_r.frame_ok)
                        report_mismatch($sformatf("frame_ok expected %b got %b",
                                                  exp_r.frame_ok, m_tuser[2]));
                end
            end
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tuser[0]);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("tb_top: FAIL");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        cfg_poly = CRC_POLY_RESET;
        cfg_init = CRC_INIT_RESET;
        frame_pos = POS_TEMP_HI;
        crc_run = CRC_INIT_RESET;
        temp_word = '0;
        temp_good = 1'b0;
        hum_hi = '0;
        hum_lo = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: value extremes, follow-on frame without a start mark,
        // mid-frame resync with a bad temperature CRC
        in_gap_pct = 20;
        out_stall_pct = 20;
        queue_frame(16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b1);
        queue_frame(16'hFFFF, 16'h0000, 1'b0, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        queue_frame(16'h6666, 16'h8000, 1'b1, 1'b0, 1'b1);
        // Temperature word of a frame that is finished after a config change
        push_byte(8'h66, 1'b1);
        push_byte(8'h2A, 1'b0);
        push_byte(word_crc(16'h662A), 1'b0);
        wait_idle();

        // New init value takes effect on the humidity word of the open frame
        write_regs(CRC_POLY_RESET, 8'h5A);
        push_byte(8'h91, 1'b0);
        push_byte(8'h0C, 1'b0);
        push_byte(word_crc(16'h910C), 1'b0);
        need_start = 1'b0;
        queue_random(380);
        wait_idle();

        run_phase(8'h00, 8'h00, 300, 0, 0, 1'b0);
        run_phase(8'hFF, 8'hFF, 300, 0, 10, 1'b1);
        run_phase(8'h07, 8'h00, 300, 50, 50, 1'b0);
        run_phase(8'($urandom), 8'($urandom), 300, 20, 20, 1'b0);
        run_phase(CRC_POLY_RESET, CRC_INIT_RESET, 230, 25, 25, 1'b0);

        if (error_count == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
